/* hw/rtl/pkb_pkg.sv */
// Shared types and constants for the PackBits run-length decoder.
`timescale 1ns / 1ps

package pkb_pkg;

    // Configuration register indexes
    localparam int CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SOURCE_LENGTH = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_OUTPUT_LENGTH = 1'b1;

    // Header byte codes
    localparam logic [7:0] HDR_NOP = 8'h80;
    // Run count is 1 - h for h in -127..-1, i.e. 257 - byte
    localparam logic [8:0] RUN_BASE = 9'd257;

    // Result queue between the front and back parts
    localparam int FIFO_DEPTH = 4;

    typedef struct packed {
        logic       start_of_body;
        logic [7:0] source_byte;
    } in_item_t;

    typedef struct packed {
        logic       data_valid;
        logic [7:0] value;
        logic [7:0] repeat_count;
        logic       done_res;
        logic       status;
    } out_item_t;

    // Write request from the front part into the queue
    typedef struct packed {
        logic      valid;
        out_item_t item;
    } pkb_push_t;

endpackage

/* hw/rtl/pkb_front.sv */
// Front part: accepts compressed bytes, tracks the decode state and forms results.
`timescale 1ns / 1ps

module pkb_front import pkb_pkg::*; #(
    parameter int LENGTH_BITS = 24
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_item_t               s_data,
    input  logic                   cfg_valid,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [LENGTH_BITS-1:0] cfg_wdata,
    input  logic                   fifo_full,
    output pkb_push_t              push
);

    localparam int W = LENGTH_BITS + 1;

    typedef enum logic [1:0] {
        MODE_FINISHED,
        MODE_HEADER,
        MODE_LITERAL,
        MODE_RUN
    } mode_t;

    mode_t                  mode_reg, mode_next;
    logic [7:0]             remain_reg, remain_next;
    logic [7:0]             run_reg, run_next;
    logic [LENGTH_BITS-1:0] src_pos_reg, src_pos_next;
    logic [LENGTH_BITS-1:0] out_pos_reg, out_pos_next;
    logic [LENGTH_BITS-1:0] src_len_reg, out_len_reg;

    logic                   accept;
    logic                   start;
    logic [7:0]             b;
    mode_t                  mode0;
    logic [7:0]             remain0, run0;
    logic [LENGTH_BITS-1:0] sp0, op0;
    logic [W-1:0]           sl_w, ol_w;
    logic [W-1:0]           sp1_w, op_step_w, end_q;
    logic [8:0]             hdr_cnt;
    logic [W-1:0]           sp_plus, op_plus;
    logic                   lit_over, run_over;
    logic                   start_end, end_hit, end_status;
    out_item_t              res;
    logic                   has_res;

    assign s_ready = !fifo_full;
    assign accept  = s_valid && s_ready;
    assign start   = s_data.start_of_body;
    assign b       = s_data.source_byte;

    // A start byte abandons the current body
    assign mode0   = start ? MODE_HEADER : mode_reg;
    assign remain0 = start ? 8'd0 : remain_reg;
    assign run0    = start ? 8'd0 : run_reg;
    assign sp0     = start ? '0 : src_pos_reg;
    assign op0     = start ? '0 : out_pos_reg;

    assign sl_w = {1'b0, src_len_reg};
    assign ol_w = {1'b0, out_len_reg};

    // Position arithmetic
    assign sp1_w     = {1'b0, sp0} + W'(1);
    assign op_step_w = {1'b0, op0} + W'((mode0 == MODE_RUN) ? run0 : 8'd1);
    assign hdr_cnt   = b[7] ? (RUN_BASE - {1'b0, b}) : ({1'b0, b} + 9'd1);
    assign sp_plus   = sp1_w + W'(hdr_cnt);
    assign op_plus   = {1'b0, op0} + W'(hdr_cnt);
    assign lit_over  = (sp_plus > sl_w) || (op_plus > ol_w);
    assign run_over  = (sp1_w >= sl_w) || (op_plus > ol_w);

    // End check after a complete header, literal or run
    assign end_q      = (mode0 == MODE_HEADER) ? {1'b0, op0} : op_step_w;
    assign end_hit    = (sp1_w >= sl_w) || (end_q >= ol_w);
    assign end_status = (end_q != ol_w);
    assign start_end  = (src_len_reg == '0) || (out_len_reg == '0);

    // Next-state and result logic
    always_comb begin
        mode_next    = mode_reg;
        remain_next  = remain_reg;
        run_next     = run_reg;
        src_pos_next = src_pos_reg;
        out_pos_next = out_pos_reg;
        res          = '0;
        has_res      = 1'b0;
        if (accept) begin
            if (start) begin
                mode_next    = MODE_HEADER;
                remain_next  = 8'd0;
                run_next     = 8'd0;
                src_pos_next = '0;
                out_pos_next = '0;
            end
            if (start && start_end) begin
                mode_next    = MODE_FINISHED;
                has_res      = 1'b1;
                res.done_res = 1'b1;
                res.status   = (out_len_reg != '0);
            end else begin
                case (mode0)
                    MODE_HEADER: begin
                        src_pos_next = sp1_w[LENGTH_BITS-1:0];
                        if (!b[7]) begin
                            if (lit_over) begin
                                mode_next    = MODE_FINISHED;
                                has_res      = 1'b1;
                                res.done_res = 1'b1;
                                res.status   = 1'b1;
                            end else begin
                                remain_next = hdr_cnt[7:0];
                                mode_next   = MODE_LITERAL;
                            end
                        end else if (b != HDR_NOP) begin
                            if (run_over) begin
                                mode_next    = MODE_FINISHED;
                                has_res      = 1'b1;
                                res.done_res = 1'b1;
                                res.status   = 1'b1;
                            end else begin
                                run_next  = hdr_cnt[7:0];
                                mode_next = MODE_RUN;
                            end
                        end else if (end_hit) begin
                            mode_next    = MODE_FINISHED;
                            has_res      = 1'b1;
                            res.done_res = 1'b1;
                            res.status   = end_status;
                        end
                    end
                    MODE_LITERAL: begin
                        src_pos_next     = sp1_w[LENGTH_BITS-1:0];
                        out_pos_next     = op_step_w[LENGTH_BITS-1:0];
                        has_res          = 1'b1;
                        res.data_valid   = 1'b1;
                        res.value        = b;
                        res.repeat_count = 8'd1;
                        remain_next      = (remain0 != 8'd0) ? remain0 - 8'd1 : 8'd0;
                        if (remain0 <= 8'd1) begin
                            mode_next = MODE_HEADER;
                            if (end_hit) begin
                                mode_next    = MODE_FINISHED;
                                res.done_res = 1'b1;
                                res.status   = end_status;
                            end
                        end
                    end
                    MODE_RUN: begin
                        src_pos_next     = sp1_w[LENGTH_BITS-1:0];
                        out_pos_next     = op_step_w[LENGTH_BITS-1:0];
                        has_res          = 1'b1;
                        res.data_valid   = 1'b1;
                        res.value        = b;
                        res.repeat_count = run0;
                        run_next         = 8'd0;
                        mode_next        = MODE_HEADER;
                        if (end_hit) begin
                            mode_next    = MODE_FINISHED;
                            res.done_res = 1'b1;
                            res.status   = end_status;
                        end
                    end
                    default: begin
                        // finished: bytes are dropped until the next start
                    end
                endcase
            end
        end
    end

    assign push.valid = has_res;
    assign push.item  = res;

    // State and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_FINISHED;
            remain_reg  <= 8'd0;
            run_reg     <= 8'd0;
            src_pos_reg <= '0;
            out_pos_reg <= '0;
            src_len_reg <= LENGTH_BITS'(1);
            out_len_reg <= '0;
        end else begin
            mode_reg    <= mode_next;
            remain_reg  <= remain_next;
            run_reg     <= run_next;
            src_pos_reg <= src_pos_next;
            out_pos_reg <= out_pos_next;
            if (cfg_valid) begin
                case (cfg_addr)
                    CFG_SOURCE_LENGTH: src_len_reg <= cfg_wdata;
                    CFG_OUTPUT_LENGTH: out_len_reg <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

/* hw/rtl/pkb_fifo.sv */
// Short result queue between the front and back parts.
`timescale 1ns / 1ps

module pkb_fifo import pkb_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  pkb_push_t push,
    input  logic      pop,
    output out_item_t head,
    output logic      empty,
    output logic      full
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    out_item_t          entries_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push, do_pop;

    assign empty   = (count_reg == CNT_W'(0));
    assign full    = (count_reg == CNT_W'(FIFO_DEPTH));
    assign do_push = push.valid && !full;
    assign do_pop  = pop && !empty;
    assign head    = entries_reg[rd_ptr_reg];

    // Entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push.item;
        end
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

/* hw/rtl/pkb_back.sv */
// Back part: moves queued results into the output register for the receiver.
`timescale 1ns / 1ps

module pkb_back import pkb_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  out_item_t head,
    input  logic      empty,
    output logic      pop,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic      m_valid_reg;
    out_item_t m_data_reg;

    // Load when the register is free or being drained this cycle
    assign pop     = !empty && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pop) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            m_data_reg <= head;
        end
    end

endmodule

/* hw/rtl/packbits_run_length_decoder.sv */
// Top level of the PackBits run-length decoder.
`timescale 1ns / 1ps
//
// Usage:
//   s_ channel: one compressed byte per request, start_of_body marks the first
//   byte of a body and restarts the counters.
//   m_ channel: zero or one result per input byte: a value/count pair, a done
//   flag with status (0 ok, 1 truncated), or both together.
//   cfg_ channel: index 0 writes source_length, index 1 writes output_length;
//   always ready, write only while no request is in flight.
// Throughput: one byte per cycle while the result queue has room; the decode
//   state is updated in the cycle a byte is accepted, so consecutive bytes never wait on each other.
// Path: a result is written into the queue at the edge that accepts its byte,
//   then loaded from the queue head into the output register when that register is free or being drained.
// Stall: a four-entry result queue sits between the decode front and the
//   output register; s_ready drops only when that queue is full.
// Reset: aresetn (synchronous, active low) empties the queue, clears m_valid,
//   sets source_length to 1, output_length to 0 and the decoder to finished,
//   so bytes are dropped until a start byte arrives.

module packbits_run_length_decoder import pkb_pkg::*; #(
    parameter int LENGTH_BITS = 24
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_item_t               s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_item_t              m_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [LENGTH_BITS-1:0] cfg_wdata
);

    pkb_push_t push;
    out_item_t head;
    logic      empty, full, pop;

    assign cfg_ready = 1'b1;

    pkb_front #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .fifo_full (full),
        .push      (push)
    );

    pkb_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (pop),
        .head    (head),
        .empty   (empty),
        .full    (full)
    );

    pkb_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (head),
        .empty   (empty),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // A result always carries data or a done flag
    a_result_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.data_valid || m_data.done_res))
        else $error("empty result on m_ channel");

    // Decoded data has a count of 1..128
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.data_valid) |->
            (m_data.repeat_count != 8'd0 && m_data.repeat_count <= 8'd128))
        else $error("repeat_count out of range");

    // No data means zero value and count
    a_nodata_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.data_valid) |->
            (m_data.value == 8'd0 && m_data.repeat_count == 8'd0))
        else $error("stale data fields without data_valid");

    // Status only accompanies done
    a_status_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.done_res) |-> !m_data.status)
        else $error("status set without done_res");

endmodule

/* tb/tb.sv */
// Self-checking testbench for the PackBits run-length decoder.
`timescale 1ns / 1ps

// Tracks the decode state of the block and holds the results it should produce
class packbits_checker;

    typedef enum logic [1:0] {
        DEC_FINISHED,
        DEC_HEADER,
        DEC_LITERAL,
        DEC_RUN
    } decode_mode_e;

    int unsigned src_limit;
    int unsigned out_limit;
    decode_mode_e mode;
    int unsigned bytes_left;
    int unsigned run_len;
    int unsigned src_pos;
    int unsigned out_pos;

    pkb_pkg::out_item_t expected_decodes[$];
    int unsigned result_num;
    int unsigned report_cap;
    int errors;

    function new();
        src_limit  = 1;
        out_limit  = 0;
        mode       = DEC_FINISHED;
        bytes_left = 0;
        run_len    = 0;
        src_pos    = 0;
        out_pos    = 0;
        result_num = 0;
        report_cap = 30;
        errors     = 0;
    endfunction

    function void set_limit(logic [pkb_pkg::CFG_ADDR_W-1:0] idx, int unsigned val);
        if (idx == pkb_pkg::CFG_SOURCE_LENGTH) begin
            src_limit = val;
        end else begin
            out_limit = val;
        end
    endfunction

    // End check: runs after a start and after each complete header, literal or run
    function bit body_over(inout pkb_pkg::out_item_t r);
        if (src_pos < src_limit && out_pos < out_limit) return 1'b0;
        mode       = DEC_FINISHED;
        r.done_res = 1'b1;
        r.status   = (out_pos != out_limit);
        return 1'b1;
    endfunction

    // Header would pass one of the lengths
    function void cut_short(inout pkb_pkg::out_item_t r);
        mode       = DEC_FINISHED;
        r.done_res = 1'b1;
        r.status   = 1'b1;
    endfunction

    // Advance the decode state by one accepted request
    function void decode_byte(pkb_pkg::in_item_t req);
        pkb_pkg::out_item_t r;
        bit produced;
        int unsigned cnt;
        logic [7:0] b;
        r        = '0;
        produced = 1'b0;
        b        = req.source_byte;

        if (req.start_of_body) begin
            src_pos    = 0;
            out_pos    = 0;
            bytes_left = 0;
            run_len    = 0;
            mode       = DEC_HEADER;
            if (body_over(r)) begin
                expected_decodes.push_back(r);
                return;
            end
        end

        case (mode)
            DEC_HEADER: begin
                src_pos++;
                if (b < pkb_pkg::HDR_NOP) begin
                    cnt = b + 1;
                    if (src_pos + cnt > src_limit || out_pos + cnt > out_limit) begin
                        cut_short(r);
                        produced = 1'b1;
                    end else begin
                        bytes_left = cnt;
                        mode       = DEC_LITERAL;
                    end
                end else if (b > pkb_pkg::HDR_NOP) begin
                    cnt = pkb_pkg::RUN_BASE - b;
                    if (src_pos >= src_limit || out_pos + cnt > out_limit) begin
                        cut_short(r);
                        produced = 1'b1;
                    end else begin
                        run_len = cnt;
                        mode    = DEC_RUN;
                    end
                end else begin
                    // no-op header still triggers the end check
                    produced = body_over(r);
                end
            end
            DEC_LITERAL: begin
                src_pos++;
                out_pos++;
                r.data_valid   = 1'b1;
                r.value        = b;
                r.repeat_count = 8'd1;
                produced       = 1'b1;
                if (bytes_left > 0) bytes_left--;
                if (bytes_left == 0) begin
                    mode = DEC_HEADER;
                    void'(body_over(r));
                end
            end
            DEC_RUN: begin
                src_pos++;
                out_pos += run_len;
                r.data_valid   = 1'b1;
                r.value        = b;
                r.repeat_count = 8'(run_len);
                produced       = 1'b1;
                run_len        = 0;
                mode           = DEC_HEADER;
                void'(body_over(r));
            end
            default: ;
        endcase

        if (produced) expected_decodes.push_back(r);
    endfunction

    task report(string what, int unsigned got_v, int unsigned want_v);
        errors++;
        if (errors <= report_cap)
            $display("result %0d %s: got %0h, want %0h", result_num, what, got_v, want_v);
    endtask

    // Compare one delivered result against the oldest outstanding one
    task check_decoded(pkb_pkg::out_item_t got);
        pkb_pkg::out_item_t want;
        result_num++;
        if (expected_decodes.size() == 0) begin
            report("arrived with nothing outstanding, raw", got, 0);
            return;
        end
        want = expected_decodes.pop_front();
        if (got.data_valid !== want.data_valid)
            report("data_valid", got.data_valid, want.data_valid);
        if (got.value !== want.value)
            report("value", got.value, want.value);
        if (got.repeat_count !== want.repeat_count)
            report("repeat_count", got.repeat_count, want.repeat_count);
        if (got.done_res !== want.done_res)
            report("done_res", got.done_res, want.done_res);
        if (got.status !== want.status)
            report("status", got.status, want.status);
    endtask

endclass

module tb;
    import pkb_pkg::*;

    localparam int LEN_W          = 24;
    localparam int RESET_CYCLES   = 12;
    localparam int DRAIN_CYCLES   = 4;
    localparam int END_CYCLES     = 8;
    localparam int HOLD_CYCLES    = 150;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_BYTES   = 2000;
    localparam int CALM_BYTES     = 300;
    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    logic             aclk = 1'b0;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    in_item_t         s_data;
    logic             m_valid;
    logic             m_ready;
    out_item_t        m_data;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [LEN_W-1:0] cfg_wdata;

    packbits_checker predictor;
    logic [7:0]      stream_bytes[$];
    int              idle_pct = 20;
    bit              hold_req = 1'b0;
    int unsigned     body_bytes = 0;
    int              quiet_cycles = 0;

    packbits_run_length_decoder #(
        .LENGTH_BITS(LEN_W)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Accepted requests feed the predictor, delivered results are checked
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) predictor.decode_byte(s_data);
        if (aresetn && m_valid && m_ready) predictor.check_decoded(m_data);
    end

    // Watchdog: too long without any handshake on any channel
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Result side: random stall bursts, plus one long hold-off on request
    initial begin
        m_ready <= 1'b1;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                m_ready <= 1'b1;
            end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    // One compressed byte, with an optional idle burst ahead of it
    task automatic send_byte(input logic sob, input logic [7:0] b);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{start_of_body: sob, source_byte: b};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Stop offering and let every outstanding result come out
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (predictor.expected_decodes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [LEN_W-1:0] val);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        predictor.set_limit(idx, val);
    endtask

    // Well-formed compressed body that decodes to target bytes
    function automatic void build_stream(input int unsigned target);
        int unsigned made;
        int unsigned room;
        int unsigned n;
        int unsigned cap;
        int unsigned pick;
        stream_bytes.delete();
        made = 0;
        while (made < target) begin
            room = target - made;
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                stream_bytes.push_back(HDR_NOP);
            end else if (pick <= 4 && room >= 2) begin
                cap = (room > 128) ? 128 : room;
                n   = $urandom_range(2, cap);
                stream_bytes.push_back(8'(RUN_BASE - 9'(n)));
                stream_bytes.push_back(8'($urandom));
                made += n;
            end else begin
                cap = (pick == 9) ? 128 : 8;
                if (cap > room) cap = room;
                n = $urandom_range(1, cap);
                stream_bytes.push_back(8'(n - 1));
                repeat (n) stream_bytes.push_back(8'($urandom));
                made += n;
            end
        end
        if (stream_bytes.size() == 0) stream_bytes.push_back(HDR_NOP);
    endfunction

    initial begin
        int unsigned phase;
        int unsigned target;
        int unsigned src_len;
        int unsigned out_len;
        int unsigned cut;
        int unsigned k;
        int unsigned bodies;

        predictor = new();
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_valid <= 1'b0;
        cfg_addr  <= CFG_SOURCE_LENGTH;
        cfg_wdata <= '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset output length is zero: the start byte only reports done
        send_byte(1'b1, HDR_NOP);

        // Literal, run, no-op, then a run that overruns the output length
        write_reg(CFG_SOURCE_LENGTH, 24'd20);
        write_reg(CFG_OUTPUT_LENGTH, 24'd10);
        send_byte(1'b1, 8'h02);
        send_byte(1'b0, 8'h00);
        send_byte(1'b0, 8'hFF);
        send_byte(1'b0, 8'h7F);
        send_byte(1'b0, 8'hFE);
        send_byte(1'b0, 8'hAA);
        send_byte(1'b0, HDR_NOP);
        send_byte(1'b0, 8'h81);
        // ignored after finish
        send_byte(1'b0, 8'h55);
        // longest literal overruns the source length
        send_byte(1'b1, 8'h7F);
        send_byte(1'b1, 8'h01);
        send_byte(1'b0, 8'h33);
        // new start abandons the literal in progress
        send_byte(1'b1, 8'hFD);
        send_byte(1'b0, 8'h44);

        // Output length shrinks mid-body, body then ends ok
        write_reg(CFG_OUTPUT_LENGTH, 24'd5);
        send_byte(1'b0, 8'h00);
        send_byte(1'b0, 8'h66);

        // Run that uses up the source, then a literal header past it
        write_reg(CFG_SOURCE_LENGTH, 24'd2);
        write_reg(CFG_OUTPUT_LENGTH, 24'd200);
        send_byte(1'b1, 8'hF0);
        send_byte(1'b0, 8'h77);
        send_byte(1'b1, 8'h01);

        // Empty output length at start
        write_reg(CFG_OUTPUT_LENGTH, 24'd0);
        send_byte(1'b1, 8'h12);
        send_byte(1'b0, 8'h12);

        // Random bodies, a few per length setting
        for (phase = 0; body_bytes < RANDOM_BYTES; phase++) begin
            if (body_bytes + CALM_BYTES > RANDOM_BYTES) begin
                idle_pct = 0;
            end else begin
                case ($urandom_range(0, 2))
                    0: idle_pct = 0;
                    1: idle_pct = 10;
                    default: idle_pct = 30;
                endcase
            end

            target = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400)
                                                 : $urandom_range(0, 30);
            if (phase == 0) target = 60;
            build_stream(target);

            src_len = stream_bytes.size();
            out_len = target;
            case ($urandom_range(0, 5))
                0: if (src_len > 1) src_len--;
                1: src_len++;
                2: out_len++;
                3: if (out_len > 0) out_len--;
                default: ;
            endcase
            // length extremes, forced early and then now and again
            k = (phase < 6) ? phase : $urandom_range(0, 15);
            case (k)
                1: src_len = LEN_MAX;
                2: out_len = LEN_MAX;
                3: src_len = 1;
                4: begin
                    src_len = LEN_MAX;
                    out_len = LEN_MAX;
                end
                5: out_len = 0;
                default: ;
            endcase
            write_reg(CFG_SOURCE_LENGTH, LEN_W'(src_len));
            write_reg(CFG_OUTPUT_LENGTH, LEN_W'(out_len));

            // long receiver hold-off while the sender keeps offering
            if (phase == 0) hold_req = 1'b1;

            bodies = $urandom_range(2, 6);
            for (k = 0; k < bodies; k++) begin
                if (k != 0) build_stream(target);
                // broken bodies: a damaged byte or an early restart
                if (stream_bytes.size() > 1 && $urandom_range(0, 9) == 0)
                    stream_bytes[$urandom_range(1, stream_bytes.size() - 1)] = 8'($urandom);
                if (stream_bytes.size() > 1 && $urandom_range(0, 9) == 0) begin
                    cut = $urandom_range(1, stream_bytes.size() - 1);
                    stream_bytes = stream_bytes[0:cut - 1];
                end
                foreach (stream_bytes[i]) begin
                    send_byte(i == 0, stream_bytes[i]);
                    body_bytes++;
                end
                // trailing noise, mostly ignored
                if ($urandom_range(0, 7) == 0)
                    repeat ($urandom_range(1, 4)) send_byte(1'b0, 8'($urandom));
            end
        end

        wait_drained();
        repeat (END_CYCLES) @(posedge aclk);
        if (predictor.expected_decodes.size() != 0)
            predictor.report("still outstanding at end, count", predictor.expected_decodes.size(), 0);
        if (predictor.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
